FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the keyframe interpolator modules.
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and codes for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  // item kinds
  localparam logic [2:0] KIND_WTIME = 3'd0;
  localparam logic [2:0] KIND_WPOS  = 3'd1;
  localparam logic [2:0] KIND_WSCL  = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FEW   = 2'd3;

  // depth of the command queue between front and back
  localparam int QDEPTH = 2;

  // work the back end has to do for one item
  typedef enum logic [2:0] {
    OP_RESP  = 3'd0,  // status only, no table access
    OP_WTIME = 3'd1,
    OP_WPOS  = 3'd2,
    OP_WSCL  = 3'd3,
    OP_READ  = 3'd4,
    OP_QUERY = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         key_index;
    logic signed [31:0] time_value;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } item_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_time;
    logic signed [31:0] pos_out_x;
    logic signed [31:0] pos_out_y;
    logic signed [31:0] pos_out_z;
    logic signed [31:0] scl_out_x;
    logic signed [31:0] scl_out_y;
    logic signed [31:0] scl_out_z;
  } item_out_t;

  // classified item as queued for the back end
  typedef struct packed {
    op_t                op;
    logic [1:0]         status;
    logic [5:0]         key_index;
    logic [6:0]         key_n;      // effective key count
    logic               chk_prev;   // time write must stay above previous key
    logic               chk_next;   // time write must stay below next key
    logic signed [31:0] time_value;
    logic [31:0]        value_x;
    logic [31:0]        value_y;
    logic [31:0]        value_z;
  } cmd_t;

endpackage

FILE: hdl/kli_chan_if.sv
// ----------------------------------------------------------------------------
// kli_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface kli_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/kli_ram.sv
// ----------------------------------------------------------------------------
// kli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/kli_front.sv
// ----------------------------------------------------------------------------
// kli_front
// Accepts items, holds the key count and classifies each item into a
// queued command with its early status.
// ----------------------------------------------------------------------------
module kli_front #(
  parameter int KEY_SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  kli_chan_if.sink       in_chan,
  kli_chan_if.sink       cfg_chan,
  input  logic           clr_done,
  input  logic           q_full,
  output logic           push,
  output kli_pkg::cmd_t  push_data
);

  logic [6:0]         key_count_r;
  logic [6:0]         key_n;
  logic [6:0]         idx_w;
  logic [6:0]         idx_inc;
  kli_pkg::item_in_t  item;

  // key count register; the user must write it only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      key_count_r <= cfg_chan.data;
    end
  end

  assign cfg_chan.ready = 1'b1;

  // take items once the table is initialized and the queue has room
  assign in_chan.ready = clr_done && !q_full;
  assign push          = in_chan.valid && in_chan.ready;
  assign item          = in_chan.data;

  // effective count and index arithmetic
  assign key_n   = (32'(key_count_r) < KEY_SLOTS) ? key_count_r : 7'(KEY_SLOTS);
  assign idx_w   = {1'b0, item.key_index};
  assign idx_inc = idx_w + 7'd1;

  // classify
  always_comb begin
    push_data            = '0;
    push_data.op         = kli_pkg::OP_RESP;
    push_data.status     = kli_pkg::ST_OK;
    push_data.key_index  = item.key_index;
    push_data.key_n      = key_n;
    push_data.time_value = item.time_value;
    push_data.value_x    = item.value_x;
    push_data.value_y    = item.value_y;
    push_data.value_z    = item.value_z;
    push_data.chk_prev   = (key_n > 7'd1) && (idx_w != 7'd0);
    push_data.chk_next   = (key_n > 7'd1) && (idx_inc < key_n);
    if (item.kind inside {[kli_pkg::KIND_WTIME:kli_pkg::KIND_READ]} && idx_w >= key_n) begin
      push_data.status = kli_pkg::ST_INDEX;
    end else begin
      case (item.kind)
        kli_pkg::KIND_WTIME: push_data.op = kli_pkg::OP_WTIME;
        kli_pkg::KIND_WPOS:  push_data.op = kli_pkg::OP_WPOS;
        kli_pkg::KIND_WSCL:  push_data.op = kli_pkg::OP_WSCL;
        kli_pkg::KIND_READ:  push_data.op = kli_pkg::OP_READ;
        kli_pkg::KIND_QUERY: begin
          if (key_n < 7'd2) begin
            push_data.status = kli_pkg::ST_FEW;
          end else begin
            push_data.op = kli_pkg::OP_QUERY;
          end
        end
        default: push_data.op = kli_pkg::OP_RESP;
      endcase
    end
  end

endmodule

FILE: hdl/kli_queue.sv
// ----------------------------------------------------------------------------
// kli_queue
// Small register FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kli_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kli_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output kli_pkg::cmd_t  pop_data
);

  localparam int PW = (kli_pkg::QDEPTH > 1) ? $clog2(kli_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(kli_pkg::QDEPTH + 1);

  kli_pkg::cmd_t ent_r [kli_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(kli_pkg::QDEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = ent_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(kli_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(kli_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `KLI_ASSERT_IMP(a_q_bound, 1'b1, count_r <= CW'(kli_pkg::QDEPTH), "queue count over depth")
  `KLI_ASSERT_IMP(a_q_no_ovf, push, !full || pop, "push into full queue")

endmodule

FILE: hdl/kli_back.sv
// ----------------------------------------------------------------------------
// kli_back
// Executes queued commands against the key table: writes, reads, time
// order checks, segment search and six-lane multiply/divide interpolation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kli_back #(
  parameter int KEY_SLOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  kli_pkg::cmd_t  q_data,
  output logic           q_pop,
  output logic           clr_done,
  kli_chan_if.source     out_chan
);

  localparam int AW        = $clog2(KEY_SLOTS);
  localparam int LANES     = 6;
  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 66;
  localparam logic [34:0] QCLAMP = 35'd1 << 34;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ISSUE  = 13'b0000000000100,
    S_RDWAIT = 13'b0000000001000,
    S_TWP    = 13'b0000000010000,
    S_TWN    = 13'b0000000100000,
    S_SCAN   = 13'b0000001000000,
    S_LDA    = 13'b0000010000000,
    S_LDB    = 13'b0000100000000,
    S_SETUP  = 13'b0001000000000,
    S_MUL    = 13'b0010000000000,
    S_DIV    = 13'b0100000000000,
    S_SUM    = 13'b1000000000000
  } state_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r;
  logic               out_full_r;
  kli_pkg::item_out_t out_q_r;
  kli_pkg::cmd_t      cmd_r;

  logic [6:0]         j_r;
  logic [6:0]         rd_j_r;
  logic               rd_pend_r;
  logic [6:0]         seg_a_r;
  logic               bad_r;
  logic [31:0]        ta_r;
  logic [31:0]        va_r   [LANES];
  logic [65:0]        mc_r   [LANES];
  logic [65:0]        acc_r  [LANES];
  logic [32:0]        rem_r  [LANES];
  logic               neg_r  [LANES];
  logic [32:0]        mplier_r;
  logic [32:0]        dsr_r;
  logic               zspan_r;
  logic [6:0]         cnt_r;

  // memory ports
  logic               t_we, p_we, s_we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        t_wdata, rd_time;
  logic [95:0]        p_wdata, s_wdata, rd_pos, rd_scl;
  logic [191:0]       rd_vec;
  logic [31:0]        lane_rd [LANES];

  // lane arithmetic
  logic signed [32:0] dt_s, span_s;
  logic signed [32:0] dv_s   [LANES];
  logic [33:0]        trial  [LANES];
  logic               ge     [LANES];
  logic [34:0]        qc     [LANES];
  logic signed [35:0] sum_s  [LANES];
  logic [31:0]        lerp_v [LANES];

  logic               res_we;
  kli_pkg::item_out_t res;
  logic               scan_found, scan_more, tw_prev_bad, tw_bad;
  logic [31:0]        one_fx;

  // key table
  kli_ram #(.WIDTH(32), .DEPTH(KEY_SLOTS)) u_time_ram (
    .clk(clk), .we(t_we), .waddr(waddr), .wdata(t_wdata), .raddr(raddr), .rdata(rd_time)
  );
  kli_ram #(.WIDTH(96), .DEPTH(KEY_SLOTS)) u_pos_ram (
    .clk(clk), .we(p_we), .waddr(waddr), .wdata(p_wdata), .raddr(raddr), .rdata(rd_pos)
  );
  kli_ram #(.WIDTH(96), .DEPTH(KEY_SLOTS)) u_scl_ram (
    .clk(clk), .we(s_we), .waddr(waddr), .wdata(s_wdata), .raddr(raddr), .rdata(rd_scl)
  );

  assign one_fx   = 32'd1 << FRAC_BITS;
  assign rd_vec   = {rd_scl, rd_pos};
  assign clr_done = (state_r != S_CLEAR);

  // segment search and time order checks
  assign scan_found  = rd_pend_r && ($signed(cmd_r.time_value) < $signed(rd_time));
  assign scan_more   = ({1'b0, j_r} + 8'd1) < {1'b0, cmd_r.key_n};
  assign tw_prev_bad = cmd_r.chk_prev && ($signed(cmd_r.time_value) <= $signed(rd_time));
  assign tw_bad      = bad_r || (cmd_r.chk_next &&
                                 ($signed(cmd_r.time_value) >= $signed(rd_time)));

  // segment deltas, shared by all lanes
  assign dt_s   = {cmd_r.time_value[31], cmd_r.time_value} - $signed({ta_r[31], ta_r});
  assign span_s = $signed({rd_time[31], rd_time}) - $signed({ta_r[31], ta_r});

  // per-lane datapath
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_rd[i] = rd_vec[32*i +: 32];
      dv_s[i]    = $signed({lane_rd[i][31], lane_rd[i]}) - $signed({va_r[i][31], va_r[i]});
      trial[i]   = {rem_r[i], acc_r[i][65]};
      ge[i]      = trial[i] >= {1'b0, dsr_r};
      qc[i]      = (acc_r[i] > 66'(QCLAMP)) ? QCLAMP : acc_r[i][34:0];
      sum_s[i]   = $signed({{4{va_r[i][31]}}, va_r[i]}) +
                   (neg_r[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]}));
      if (zspan_r) begin
        lerp_v[i] = va_r[i];
      end else if (sum_s[i] > 36'sd2147483647) begin
        lerp_v[i] = 32'h7FFF_FFFF;
      end else if (sum_s[i] < -36'sd2147483648) begin
        lerp_v[i] = 32'h8000_0000;
      end else begin
        lerp_v[i] = sum_s[i][31:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    t_we         = 1'b0;
    p_we         = 1'b0;
    s_we         = 1'b0;
    waddr        = AW'(cmd_r.key_index);
    raddr        = '0;
    t_wdata      = cmd_r.time_value;
    p_wdata      = {cmd_r.value_z, cmd_r.value_y, cmd_r.value_x};
    s_wdata      = {cmd_r.value_z, cmd_r.value_y, cmd_r.value_x};
    res_we       = 1'b0;
    res          = '0;
    res.status   = cmd_r.status;
    res.out_time = cmd_r.time_value;
    case (state_r)
      S_CLEAR: begin
        t_we    = 1'b1;
        p_we    = 1'b1;
        s_we    = 1'b1;
        waddr   = clr_addr_r;
        t_wdata = 32'(clr_addr_r) << FRAC_BITS;
        p_wdata = '0;
        s_wdata = {one_fx, one_fx, one_fx};
        if (clr_addr_r == AW'(KEY_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && !out_full_r) begin
          q_pop     = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (cmd_r.op)
          kli_pkg::OP_WPOS: begin
            p_we      = 1'b1;
            res_we    = 1'b1;
            state_nxt = S_IDLE;
          end
          kli_pkg::OP_WSCL: begin
            s_we      = 1'b1;
            res_we    = 1'b1;
            state_nxt = S_IDLE;
          end
          kli_pkg::OP_READ: begin
            raddr     = AW'(cmd_r.key_index);
            state_nxt = S_RDWAIT;
          end
          kli_pkg::OP_WTIME: begin
            raddr     = AW'(cmd_r.key_index - 6'd1);
            state_nxt = S_TWP;
          end
          kli_pkg::OP_QUERY: begin
            state_nxt = S_SCAN;
          end
          default: begin
            res_we    = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RDWAIT: begin
        res.out_time  = rd_time;
        res.pos_out_x = rd_pos[31:0];
        res.pos_out_y = rd_pos[63:32];
        res.pos_out_z = rd_pos[95:64];
        res.scl_out_x = rd_scl[31:0];
        res.scl_out_y = rd_scl[63:32];
        res.scl_out_z = rd_scl[95:64];
        res_we        = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_TWP: begin
        raddr     = AW'({1'b0, cmd_r.key_index} + 7'd1);
        state_nxt = S_TWN;
      end
      S_TWN: begin
        if (tw_bad) begin
          res.status = kli_pkg::ST_ORDER;
        end else begin
          t_we = 1'b1;
        end
        res_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan_found || !scan_more) begin
          state_nxt = S_LDA;
        end else begin
          raddr = AW'(j_r);
        end
      end
      S_LDA: begin
        raddr     = AW'(seg_a_r);
        state_nxt = S_LDB;
      end
      S_LDB: begin
        raddr     = AW'(seg_a_r + 7'd1);
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (cnt_r == 7'(MUL_STEPS - 1)) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        res.pos_out_x = lerp_v[0];
        res.pos_out_y = lerp_v[1];
        res.pos_out_z = lerp_v[2];
        res.scl_out_x = lerp_v[3];
        res.scl_out_y = lerp_v[4];
        res.scl_out_z = lerp_v[5];
        res_we        = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      out_full_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (res_we) begin
        out_full_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_full_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (res_we) begin
      out_q_r <= res;
    end
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cmd_r <= q_data;
        end
      end
      S_ISSUE: begin
        j_r       <= 7'd1;
        rd_pend_r <= 1'b0;
      end
      S_TWP: begin
        bad_r <= tw_prev_bad;
      end
      S_SCAN: begin
        if (scan_found) begin
          seg_a_r <= rd_j_r - 7'd1;
        end else if (scan_more) begin
          rd_pend_r <= 1'b1;
          rd_j_r    <= j_r;
          j_r       <= j_r + 7'd1;
        end else begin
          seg_a_r <= cmd_r.key_n - 7'd2;
        end
      end
      S_LDB: begin
        ta_r <= rd_time;
        for (int i = 0; i < LANES; i++) begin
          va_r[i] <= lane_rd[i];
        end
      end
      S_SETUP: begin
        mplier_r <= mag33(dt_s);
        dsr_r    <= mag33(span_s);
        zspan_r  <= (span_s == '0);
        cnt_r    <= '0;
        for (int i = 0; i < LANES; i++) begin
          mc_r[i]  <= 66'(mag33(dv_s[i]));
          acc_r[i] <= '0;
          neg_r[i] <= dv_s[i][32] ^ dt_s[32] ^ span_s[32];
        end
      end
      S_MUL: begin
        // shift-add multiply, one multiplier bit per cycle
        mplier_r <= mplier_r >> 1;
        cnt_r    <= (cnt_r == 7'(MUL_STEPS - 1)) ? '0 : cnt_r + 7'd1;
        for (int i = 0; i < LANES; i++) begin
          mc_r[i] <= mc_r[i] << 1;
          if (mplier_r[0]) begin
            acc_r[i] <= acc_r[i] + mc_r[i];
          end
          rem_r[i] <= '0;
        end
      end
      S_DIV: begin
        // restoring divide, quotient bits shift into the product register
        cnt_r <= cnt_r + 7'd1;
        for (int i = 0; i < LANES; i++) begin
          rem_r[i] <= ge[i] ? 33'(trial[i] - {1'b0, dsr_r}) : trial[i][32:0];
          acc_r[i] <= {acc_r[i][64:0], ge[i]};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid = out_full_r;
  assign out_chan.data  = out_q_r;

  `KLI_ASSERT_IMP(a_bk_res_room, res_we, !out_full_r, "result overwrites pending result")
  `KLI_ASSERT_IMP(a_bk_clear_quiet, state_r == S_CLEAR, !q_valid, "command queued during clear")
  `KLI_ASSERT_NXT(a_bk_mul_div, (state_r == S_MUL) && (cnt_r == 7'(MUL_STEPS - 1)),
                  (state_r == S_DIV) && (cnt_r == '0), "multiply did not hand over to divide")

endmodule

FILE: hdl/keyframe_linear_interpolator_unit.sv
// For a query, the segment scan reads one key time a cycle, then a shift-add
// multiply and a restoring divide run in six lanes. One item is worked at a
// time; the next starts the cycle after its result is taken, and a 2-entry
// queue keeps accepting. Reset clears the table; no item is taken meanwhile.
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// Keyframe table with piecewise linear interpolation of position and scale.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit #(
  parameter int KEY_SLOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  kli_chan_if.sink    in_chan,
  kli_chan_if.source  out_chan,
  kli_chan_if.sink    cfg_chan
);

  logic          clr_done;
  logic          q_full;
  logic          push;
  logic          q_valid;
  logic          q_pop;
  kli_pkg::cmd_t push_data;
  kli_pkg::cmd_t q_data;

  // accept and classify
  kli_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .cfg_chan(cfg_chan),
    .clr_done(clr_done), .q_full(q_full), .push(push), .push_data(push_data)
  );

  // command queue
  kli_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_data(q_data)
  );

  // table and interpolation
  kli_back #(.KEY_SLOTS(KEY_SLOTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .clr_done(clr_done), .out_chan(out_chan)
  );

endmodule
